### sv/utcc_pkg.sv
// Shared types, codes and constant tables of the Unix time calendar converter.
`timescale 1ns / 1ps
`default_nettype none
package utcc_pkg;

   localparam logic [1:0] MODE_DECODE   = 2'd0;
   localparam logic [1:0] MODE_ENCODE   = 2'd1;

   localparam logic       CSR_TZ_OFFSET = 1'b0;
   localparam logic       CSR_MODE      = 1'b1;

   typedef enum logic [2:0] {
      DIV_DAY,
      DIV_HOUR,
      DIV_MIN,
      DIV_WEEK,
      DIV_CYCLE
   } div_sel_type;

   typedef enum logic [1:0] {
      KIND_DEC,
      KIND_ENC,
      KIND_ERR
   } res_kind_type;

   typedef struct packed {
      logic [31:0] epoch_in;
      logic [5:0]  sec_in;
      logic [5:0]  min_in;
      logic [4:0]  hour_in;
      logic [4:0]  day_in;
      logic [3:0]  month_in;
      logic [6:0]  year_in;
   } req_type;

   typedef struct packed {
      logic [31:0] epoch_out;
      logic [5:0]  sec_out;
      logic [5:0]  min_out;
      logic [4:0]  hour_out;
      logic [2:0]  weekday_out;
      logic [4:0]  day_out;
      logic [3:0]  month_out;
      logic [6:0]  year_out;
      logic        status;
   } res_type;

   typedef struct packed {
      logic         load;
      logic         div_mul;
      logic         div_fix;
      div_sel_type  div_sel;
      logic         year_fix;
      logic         month_step;
      logic         enc_days;
      logic         enc_mul;
      logic         enc_sum;
      logic         finish;
      res_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic month_done;
      logic out_free;
   } dp_sts_type;

   // floor(2^s / d), s chosen per divisor so that one correction step suffices
   function automatic logic [15:0] div_magic(input div_sel_type sel);
      case (sel)
         DIV_DAY:   return 16'd49710;
         DIV_HOUR:  return 16'd36;
         DIV_MIN:   return 16'd68;
         DIV_WEEK:  return 16'd9362;
         DIV_CYCLE: return 16'd44;
         default:   return 16'd0;
      endcase
   endfunction

   function automatic logic [16:0] div_const(input div_sel_type sel);
      case (sel)
         DIV_DAY:   return 17'd86400;
         DIV_HOUR:  return 17'd3600;
         DIV_MIN:   return 17'd60;
         DIV_WEEK:  return 17'd7;
         DIV_CYCLE: return 17'd1461;
         default:   return 17'd1;
      endcase
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      case (idx)
         4'd1:                      return leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   return 5'd30;
         default:                   return 5'd31;
      endcase
   endfunction

   // days before the first of a month; month zero counts as January
   function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
      logic [8:0] l;
      l = {8'd0, leap};
      case (mon)
         4'd0, 4'd1: return 9'd0;
         4'd2:       return 9'd31;
         4'd3:       return 9'd59 + l;
         4'd4:       return 9'd90 + l;
         4'd5:       return 9'd120 + l;
         4'd6:       return 9'd151 + l;
         4'd7:       return 9'd181 + l;
         4'd8:       return 9'd212 + l;
         4'd9:       return 9'd243 + l;
         4'd10:      return 9'd273 + l;
         4'd11:      return 9'd304 + l;
         4'd12:      return 9'd334 + l;
         4'd13:      return 9'd365 + l;
         4'd14:      return 9'd396 + l;
         4'd15:      return 9'd427 + l;
         default:    return 9'd0;
      endcase
   endfunction

   function automatic logic [31:0] offset_seconds(input logic signed [4:0] hours);
      logic signed [31:0] prod;
      prod = 32'(hours) * 32'sd3600;
      return 32'(unsigned'(prod));
   endfunction

endpackage
`default_nettype wire

### sv/utcc_ctrl.sv
// Sequencing state machine of the Unix time calendar converter.
`timescale 1ns / 1ps
`default_nettype none
module utcc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [1:0]          mode,
   input  wire utcc_pkg::dp_sts_type sts,
   output utcc_pkg::dp_cmd_type     cmd
);
   import utcc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DIV_MUL  = 9'b000000010,
      ST_DIV_FIX  = 9'b000000100,
      ST_YEAR     = 9'b000001000,
      ST_MONTH    = 9'b000010000,
      ST_ENC_DAYS = 9'b000100000,
      ST_ENC_MUL  = 9'b001000000,
      ST_ENC_SUM  = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type    state_ff,   state_in;
   div_sel_type  div_sel_ff, div_sel_in;
   res_kind_type kind_ff,    kind_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      div_sel_in = div_sel_ff;
      kind_in    = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (mode == MODE_DECODE) begin
                  state_in   = ST_DIV_MUL;
                  div_sel_in = DIV_DAY;
                  kind_in    = KIND_DEC;
               end else if (mode == MODE_ENCODE) begin
                  state_in = ST_ENC_DAYS;
                  kind_in  = KIND_ENC;
               end else begin
                  state_in = ST_FINISH;
                  kind_in  = KIND_ERR;
               end
            end
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_DIV_MUL;
            case (div_sel_ff)
               DIV_DAY:  div_sel_in = DIV_HOUR;
               DIV_HOUR: div_sel_in = DIV_MIN;
               DIV_MIN:  div_sel_in = DIV_WEEK;
               DIV_WEEK: div_sel_in = DIV_CYCLE;
               default:  state_in   = ST_YEAR;
            endcase
         end
         ST_YEAR: begin
            cmd.year_fix = 1'b1;
            state_in     = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (sts.month_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_ENC_DAYS: begin
            cmd.enc_days = 1'b1;
            state_in     = ST_ENC_MUL;
         end
         ST_ENC_MUL: begin
            cmd.enc_mul = 1'b1;
            state_in    = ST_ENC_SUM;
         end
         ST_ENC_SUM: begin
            cmd.enc_sum = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.div_sel = div_sel_ff;
      cmd.kind    = kind_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_sel_ff <= DIV_DAY;
         kind_ff    <= KIND_DEC;
      end else begin
         state_ff   <= state_in;
         div_sel_ff <= div_sel_in;
         kind_ff    <= kind_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice in a row");

   a_cycle_div_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV_FIX) && (div_sel_ff == DIV_CYCLE)) |=> (state_ff == ST_YEAR))
      else $error("division chain did not end at the year step");

endmodule
`default_nettype wire

### sv/utcc_dp.sv
// Datapath of the Unix time calendar converter: shared constant divider,
// year and month walk, encode arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module utcc_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire utcc_pkg::dp_cmd_type cmd,
   input  wire utcc_pkg::req_type    req,
   input  wire logic signed [4:0]    tz,
   input  wire logic                 rsp_tready,
   output logic                      rsp_valid,
   output utcc_pkg::res_type         res,
   output utcc_pkg::dp_sts_type      sts
);
   import utcc_pkg::*;

   req_type     in_ff,    in_in;
   logic [31:0] num_ff,   num_in;
   logic [15:0] q_ff,     q_in;
   logic [15:0] days_ff,  days_in;
   logic [4:0]  hour_ff,  hour_in;
   logic [5:0]  min_ff,   min_in;
   logic [5:0]  sec_ff,   sec_in;
   logic [2:0]  wday_ff,  wday_in;
   logic [11:0] year_ff,  year_in;
   logic [10:0] dd_ff,    dd_in;
   logic [3:0]  m_ff,     m_in;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     res_ff,   res_in;

   logic [31:0] off_sec;
   logic [15:0] magic;
   logic [16:0] dconst;
   logic [47:0] mul_prod;
   logic [15:0] q_est;
   logic [32:0] fix_prod;
   logic [31:0] fix_rem;
   logic        fix_carry;
   logic [15:0] q_fixed;
   logic [31:0] r_fixed;
   logic        leap_dec;
   logic [4:0]  mlen;
   logic        step_ok;
   logic [11:0] yr_mod;
   logic [11:0] enc_y;
   logic [11:0] enc_ym1;
   logic [11:0] enc_span;
   logic        enc_leap;
   logic [31:0] enc_days;
   logic [31:0] enc_scaled;
   logic [31:0] enc_total;

   assign off_sec  = offset_seconds(tz);
   assign magic    = div_magic(cmd.div_sel);
   assign dconst   = div_const(cmd.div_sel);
   assign mul_prod = num_ff * magic;

   always_comb begin
      case (cmd.div_sel)
         DIV_DAY:   q_est = mul_prod[47:32];
         DIV_HOUR:  q_est = mul_prod[32:17];
         DIV_MIN:   q_est = mul_prod[27:12];
         DIV_WEEK:  q_est = mul_prod[31:16];
         DIV_CYCLE: q_est = mul_prod[31:16];
         default:   q_est = mul_prod[47:32];
      endcase
   end

   assign fix_prod  = q_ff * dconst;
   assign fix_rem   = num_ff - fix_prod[31:0];
   assign fix_carry = (fix_rem >= {15'd0, dconst});
   assign q_fixed   = fix_carry ? (q_ff + 16'd1) : q_ff;
   assign r_fixed   = fix_carry ? (fix_rem - {15'd0, dconst}) : fix_rem;

   assign leap_dec = (year_ff[1:0] == 2'b00);
   assign mlen     = month_len(m_ff, leap_dec);
   assign step_ok  = (m_ff < 4'd11) && (dd_ff >= {6'd0, mlen});

   always_comb begin
      if (year_ff >= 12'd2100) begin
         yr_mod = year_ff - 12'd2100;
      end else if (year_ff >= 12'd2000) begin
         yr_mod = year_ff - 12'd2000;
      end else begin
         yr_mod = year_ff - 12'd1900;
      end
   end

   assign enc_y      = (in_ff.year_in >= 7'd70) ? (12'd1900 + {5'd0, in_ff.year_in})
                                                : (12'd2000 + {5'd0, in_ff.year_in});
   assign enc_ym1    = enc_y - 12'd1;
   assign enc_span   = enc_y - 12'd1970;
   assign enc_leap   = (enc_y[1:0] == 2'b00);
   assign enc_days   = 32'(enc_span[7:0]) * 32'd365 + 32'(enc_ym1[11:2]) - 32'd492
                     + 32'(cum_days(in_ff.month_in, enc_leap))
                     + 32'(in_ff.day_in) - 32'd1;
   assign enc_scaled = num_ff * 32'd86400;
   assign enc_total  = num_ff + 32'(in_ff.hour_in) * 32'd3600
                     + 32'(in_ff.min_in) * 32'd60 + 32'(in_ff.sec_in) - off_sec;

   always_comb begin
      in_in        = in_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      wday_in      = wday_ff;
      year_in      = year_ff;
      dd_in        = dd_ff;
      m_in         = m_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         in_in  = req;
         num_in = req.epoch_in + off_sec;
      end
      if (cmd.div_mul) begin
         q_in = q_est;
      end
      if (cmd.div_fix) begin
         case (cmd.div_sel)
            DIV_DAY: begin
               days_in = q_fixed;
               num_in  = {15'd0, r_fixed[16:0]};
            end
            DIV_HOUR: begin
               hour_in = q_fixed[4:0];
               num_in  = r_fixed;
            end
            DIV_MIN: begin
               min_in = q_fixed[5:0];
               sec_in = r_fixed[5:0];
               num_in = {16'd0, days_ff} + 32'd3;
            end
            DIV_WEEK: begin
               wday_in = r_fixed[2:0] + 3'd1;
               num_in  = {16'd0, days_ff};
            end
            DIV_CYCLE: begin
               year_in = 12'd1970 + {q_fixed[9:0], 2'b00};
               dd_in   = r_fixed[10:0];
            end
            default: begin
               num_in = num_ff;
            end
         endcase
      end
      if (cmd.year_fix) begin
         m_in = 4'd0;
         if (dd_ff >= 11'd1096) begin
            year_in = year_ff + 12'd3;
            dd_in   = dd_ff - 11'd1096;
         end else if (dd_ff >= 11'd730) begin
            year_in = year_ff + 12'd2;
            dd_in   = dd_ff - 11'd730;
         end else if (dd_ff >= 11'd365) begin
            year_in = year_ff + 12'd1;
            dd_in   = dd_ff - 11'd365;
         end
      end
      if (cmd.month_step && step_ok) begin
         dd_in = dd_ff - {6'd0, mlen};
         m_in  = m_ff + 4'd1;
      end
      if (cmd.enc_days) begin
         num_in = enc_days;
      end
      if (cmd.enc_mul) begin
         num_in = enc_scaled;
      end
      if (cmd.enc_sum) begin
         num_in = enc_total;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;
         case (cmd.kind)
            KIND_DEC: begin
               res_in.sec_out     = sec_ff;
               res_in.min_out     = min_ff;
               res_in.hour_out    = hour_ff;
               res_in.weekday_out = wday_ff;
               res_in.day_out     = dd_ff[4:0] + 5'd1;
               res_in.month_out   = m_ff + 4'd1;
               res_in.year_out    = yr_mod[6:0];
            end
            KIND_ENC: begin
               res_in.epoch_out = num_ff;
            end
            default: begin
               res_in.status = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      days_ff <= days_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      wday_ff <= wday_in;
      year_ff <= year_in;
      dd_ff   <= dd_in;
      m_ff    <= m_in;
      res_ff  <= res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign res            = res_ff;
   assign sts.month_done = !step_ok;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result valid without a finish command");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transaction");

   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (m_ff <= 4'd11))
      else $error("month walk ran past December");

endmodule
`default_nettype wire

### sv/unix_time_calendar_converter_core.sv
// Top level of the Unix time calendar converter: stream ports and configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// Converts a 32-bit Unix time to calendar fields (mode 0) or a two-digit-year
// date and time back to Unix seconds (mode 1), shifted by a whole-hour zone
// offset; modes 2 and 3 return status 1 with all other fields zero. One
// transaction is worked at a time. A decode runs five constant divisions
// that share one reciprocal-multiply unit, each as a multiply step and a
// correction step, then walks the months one at a time. An encode runs a
// day count, a scaling to seconds and a final sum; an invalid mode goes
// straight to the result. The input is ready again the cycle after the
// result is loaded, while that result still waits in the output register.
// Write the configuration only while no transaction is in flight.
module unix_time_calendar_converter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // epoch_in, sec_in, min_in, hour_in, day_in, month_in, year_in, zero pad
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // epoch_out, sec_out, min_out, hour_out, weekday_out, day_out, month_out,
   // year_out, zero pad
   output logic [71:0]      rsp_tdata,
   // status
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [4:0]  csr_wdata
);
   import utcc_pkg::*;

   logic signed [4:0] tz_offset_hours_ff;
   logic [1:0]        conversion_mode_ff;
   req_type           req;
   res_type           res;
   dp_cmd_type        cmd;
   dp_sts_type        sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_hours_ff <= 5'sd0;
         conversion_mode_ff <= MODE_DECODE;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TZ_OFFSET: tz_offset_hours_ff <= signed'(csr_wdata);
            CSR_MODE:      conversion_mode_ff <= csr_wdata[1:0];
            default:       conversion_mode_ff <= conversion_mode_ff;
         endcase
      end
   end

   assign req.epoch_in = req_tdata[31:0];
   assign req.sec_in   = req_tdata[37:32];
   assign req.min_in   = req_tdata[43:38];
   assign req.hour_in  = req_tdata[48:44];
   assign req.day_in   = req_tdata[53:49];
   assign req.month_in = req_tdata[57:54];
   assign req.year_in  = req_tdata[64:58];

   utcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (conversion_mode_ff),
      .sts        (sts),
      .cmd        (cmd)
   );

   utcc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req),
      .tz         (tz_offset_hours_ff),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .res        (res),
      .sts        (sts)
   );

   assign rsp_tdata = {4'd0, res.year_out, res.month_out, res.day_out, res.weekday_out,
                       res.hour_out, res.min_out, res.sec_out, res.epoch_out};
   assign rsp_tuser = res.status;

endmodule
`default_nettype wire
